@@ rtl/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the streaming UTF-8 decoder: byte classes,
// stop reasons, result kinds, register indexes and the queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

    // Default width of the saturating character and byte counters
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int CP_W      = 31;
    localparam int BUF_W     = 16;
    localparam int OUT_CNT_W = 16;
    localparam int LEN_W     = 3;
    localparam int PAYLOAD_W = 7;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register indexes on the configuration port
    localparam logic CFG_BUFFER_CHARS = 1'b0;
    localparam logic CFG_WIDE_16BIT   = 1'b1;

    // Result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Byte classes produced by the front end
    typedef enum logic [1:0] {
        CLS_ASCII = 2'd0,
        CLS_LEAD  = 2'd1,
        CLS_CONT  = 2'd2,
        CLS_BAD   = 2'd3
    } byte_class_t;

    // Why decoding stopped
    typedef enum logic [1:0] {
        REASON_END      = 2'd0,
        REASON_INVALID  = 2'd1,
        REASON_TOO_WIDE = 2'd2,
        REASON_BUF_FULL = 2'd3
    } reason_t;

    // One classified input item
    typedef struct packed {
        logic                 present;
        logic                 eos;
        byte_class_t          cls;
        logic [LEN_W-1:0]     lead_len;   // continuation bytes that follow a lead
        logic [PAYLOAD_W-1:0] payload;    // data bits of the byte
    } item_t;

endpackage : u8d_pkg

`default_nettype wire

@@ rtl/u8d_front.sv @@
// ----------------------------------------------------------------------------
// u8d_front
// Input side: takes byte requests, classifies each byte (ASCII, lead,
// continuation, invalid), strips the marker bits and pushes the result
// into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_front (
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              byte_present,
    input  wire logic              end_of_string,
    input  wire logic              q_full,
    output logic                   q_push,
    output u8d_pkg::item_t         q_item
);

    // Handshake: take a request whenever the queue has room
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Byte classifier
    always_comb
    begin
        q_item          = '0;
        q_item.present  = byte_present;
        q_item.eos      = end_of_string;
        if (!data_byte[7])
        begin
            q_item.cls     = u8d_pkg::CLS_ASCII;
            q_item.payload = data_byte[6:0];
        end
        else if (data_byte[7:6] == 2'b10)
        begin
            q_item.cls     = u8d_pkg::CLS_CONT;
            q_item.payload = {1'b0, data_byte[5:0]};
        end
        else if (data_byte[7:5] == 3'b110)
        begin
            q_item.cls      = u8d_pkg::CLS_LEAD;
            q_item.lead_len = 3'd1;
            q_item.payload  = {2'b0, data_byte[4:0]};
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            q_item.cls      = u8d_pkg::CLS_LEAD;
            q_item.lead_len = 3'd2;
            q_item.payload  = {3'b0, data_byte[3:0]};
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            q_item.cls      = u8d_pkg::CLS_LEAD;
            q_item.lead_len = 3'd3;
            q_item.payload  = {4'b0, data_byte[2:0]};
        end
        else if (data_byte[7:2] == 6'b111110)
        begin
            q_item.cls      = u8d_pkg::CLS_LEAD;
            q_item.lead_len = 3'd4;
            q_item.payload  = {5'b0, data_byte[1:0]};
        end
        else if (data_byte[7:1] == 7'b1111110)
        begin
            q_item.cls      = u8d_pkg::CLS_LEAD;
            q_item.lead_len = 3'd5;
            q_item.payload  = {6'b0, data_byte[0]};
        end
        else
        begin
            // 0xFE and 0xFF
            q_item.cls = u8d_pkg::CLS_BAD;
        end
    end

endmodule : u8d_front

`default_nettype wire

@@ rtl/u8d_queue.sv @@
// ----------------------------------------------------------------------------
// u8d_queue
// Short FIFO of classified items between front and back, so that either
// side can stall without stopping the other at once.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire u8d_pkg::item_t  push_item,
    input  wire logic            pop,
    output u8d_pkg::item_t       head,
    output logic                 head_valid,
    output logic                 full
);

    localparam int PTR_W = (u8d_pkg::QUEUE_DEPTH > 1) ? $clog2(u8d_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(u8d_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(u8d_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(u8d_pkg::QUEUE_DEPTH - 1);

    u8d_pkg::item_t   mem [u8d_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule : u8d_queue

`default_nettype wire

@@ rtl/u8d_back.sv @@
// ----------------------------------------------------------------------------
// u8d_back
// Decode side: pops classified bytes, builds code points, keeps the
// saturating counters and the stop status, and drives the result register.
// An item that gives a character and a summary parks the summary in a
// pending register until the result register is free again.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_back #(
    parameter int COUNT_WIDTH = u8d_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire u8d_pkg::item_t                   head,
    input  wire logic                             head_valid,
    output logic                                  pop,
    input  wire logic [u8d_pkg::BUF_W-1:0]        buffer_chars,
    input  wire logic                             wide_16bit,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  kind,
    output logic [u8d_pkg::CP_W-1:0]              code_point,
    output logic [u8d_pkg::OUT_CNT_W-1:0]         chars_decoded,
    output logic [u8d_pkg::OUT_CNT_W-1:0]         bytes_consumed,
    output logic [1:0]                            stop_reason,
    output logic                                  last
);

    localparam int CMP_W = (COUNT_WIDTH > u8d_pkg::BUF_W) ? COUNT_WIDTH : u8d_pkg::BUF_W;
    localparam int CP_W  = u8d_pkg::CP_W;
    localparam int LEN_W = u8d_pkg::LEN_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Decoder state
    logic [LEN_W-1:0]       bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]       seq_length_reg, seq_length_next;
    logic [CP_W-1:0]        acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0] bytes_done_reg, bytes_done_next;
    logic [COUNT_WIDTH-1:0] chars_done_reg, chars_done_next;
    logic                   halted_reg, halted_next;
    u8d_pkg::reason_t       halt_cause_reg, halt_cause_next;

    // Result register and pending summary
    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic [CP_W-1:0]        out_cp_reg, out_cp_next;
    logic [u8d_pkg::OUT_CNT_W-1:0] out_chars_reg, out_chars_next;
    logic [u8d_pkg::OUT_CNT_W-1:0] out_bytes_reg, out_bytes_next;
    u8d_pkg::reason_t       out_reason_reg, out_reason_next;
    logic                   out_last_reg, out_last_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [u8d_pkg::OUT_CNT_W-1:0] pend_chars_reg, pend_chars_next;
    logic [u8d_pkg::OUT_CNT_W-1:0] pend_bytes_reg, pend_bytes_next;
    u8d_pkg::reason_t       pend_reason_reg, pend_reason_next;

    // Step results
    logic                   slot_free;
    logic                   done;
    logic [CP_W-1:0]        done_cp;
    logic [LEN_W-1:0]       done_len;
    logic [CP_W-1:0]        acc_shift;
    logic [LEN_W-1:0]       left_dec;
    logic [COUNT_WIDTH:0]   bytes_sum;
    logic                   emit_char;
    logic [CP_W-1:0]        char_cp;
    logic [CMP_W-1:0]       chars_ext;
    logic [CMP_W-1:0]       bytes_ext;
    logic [u8d_pkg::OUT_CNT_W-1:0] sum_chars;
    logic [u8d_pkg::OUT_CNT_W-1:0] sum_bytes;
    u8d_pkg::reason_t       sum_reason;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = head_valid && !pend_valid_reg && slot_free;

    assign acc_shift = {acc_reg[CP_W-7:0], head.payload[5:0]};
    assign left_dec  = bytes_left_reg - 1'b1;

    // Byte decode, counting and end-of-string handling for the head item
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        seq_length_next = seq_length_reg;
        acc_next        = acc_reg;
        bytes_done_next = bytes_done_reg;
        chars_done_next = chars_done_reg;
        halted_next     = halted_reg;
        halt_cause_next = halt_cause_reg;
        done            = 1'b0;
        done_cp         = '0;
        done_len        = '0;
        emit_char       = 1'b0;
        char_cp         = '0;
        bytes_sum       = '0;
        chars_ext       = '0;
        bytes_ext       = '0;
        sum_reason      = u8d_pkg::REASON_END;

        // Sequence assembly
        if (head.present && !halted_reg)
        begin
            if (bytes_left_reg == '0)
            begin
                unique case (head.cls)
                    u8d_pkg::CLS_ASCII:
                    begin
                        done     = 1'b1;
                        done_cp  = CP_W'(head.payload);
                        done_len = LEN_W'(1);
                    end
                    u8d_pkg::CLS_LEAD:
                    begin
                        acc_next        = CP_W'(head.payload);
                        bytes_left_next = head.lead_len;
                        seq_length_next = head.lead_len + 1'b1;
                    end
                    default:
                    begin
                        // stray continuation or 0xFE/0xFF
                        halted_next     = 1'b1;
                        halt_cause_next = u8d_pkg::REASON_INVALID;
                    end
                endcase
            end
            else if (head.cls != u8d_pkg::CLS_CONT)
            begin
                halted_next     = 1'b1;
                halt_cause_next = u8d_pkg::REASON_INVALID;
                bytes_left_next = '0;
                seq_length_next = '0;
                acc_next        = '0;
            end
            else if (left_dec == '0)
            begin
                done     = 1'b1;
                done_cp  = acc_shift;
                done_len = seq_length_reg;
            end
            else
            begin
                acc_next        = acc_shift;
                bytes_left_next = left_dec;
            end
        end

        // Completed character
        if (done)
        begin
            bytes_left_next = '0;
            seq_length_next = '0;
            acc_next        = '0;
            if (wide_16bit && (done_cp[CP_W-1:16] != '0))
            begin
                halted_next     = 1'b1;
                halt_cause_next = u8d_pkg::REASON_TOO_WIDE;
            end
            else
            begin
                chars_done_next = (chars_done_reg == CNT_MAX) ? chars_done_reg
                                                              : chars_done_reg + 1'b1;
                bytes_sum       = {1'b0, bytes_done_reg} + (COUNT_WIDTH+1)'(done_len);
                bytes_done_next = (bytes_sum > {1'b0, CNT_MAX}) ? CNT_MAX
                                                                : bytes_sum[COUNT_WIDTH-1:0];
                if (buffer_chars != '0)
                begin
                    emit_char = 1'b1;
                    char_cp   = done_cp;
                    if (CMP_W'(chars_done_next) == CMP_W'(buffer_chars))
                    begin
                        halted_next     = 1'b1;
                        halt_cause_next = u8d_pkg::REASON_BUF_FULL;
                    end
                end
            end
        end

        // Summary fields, then clear for the next string
        chars_ext = CMP_W'(chars_done_next);
        bytes_ext = CMP_W'(bytes_done_next);
        if (halted_next)
        begin
            sum_reason = halt_cause_next;
        end
        else if (bytes_left_next != '0)
        begin
            sum_reason = u8d_pkg::REASON_INVALID;
        end
        if (head.eos)
        begin
            bytes_left_next = '0;
            seq_length_next = '0;
            acc_next        = '0;
            bytes_done_next = '0;
            chars_done_next = '0;
            halted_next     = 1'b0;
            halt_cause_next = u8d_pkg::REASON_END;
        end
    end

    assign sum_chars = chars_ext[u8d_pkg::OUT_CNT_W-1:0];
    assign sum_bytes = bytes_ext[u8d_pkg::OUT_CNT_W-1:0];

    // Result register and pending summary
    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ready;
        out_kind_next    = out_kind_reg;
        out_cp_next      = out_cp_reg;
        out_chars_next   = out_chars_reg;
        out_bytes_next   = out_bytes_reg;
        out_reason_next  = out_reason_reg;
        out_last_next    = out_last_reg;
        pend_valid_next  = pend_valid_reg;
        pend_chars_next  = pend_chars_reg;
        pend_bytes_next  = pend_bytes_reg;
        pend_reason_next = pend_reason_reg;

        if (pend_valid_reg && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = u8d_pkg::KIND_SUMMARY;
            out_cp_next     = '0;
            out_chars_next  = pend_chars_reg;
            out_bytes_next  = pend_bytes_reg;
            out_reason_next = pend_reason_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (pop)
        begin
            if (emit_char)
            begin
                out_valid_next   = 1'b1;
                out_kind_next    = u8d_pkg::KIND_CHAR;
                out_cp_next      = char_cp;
                out_chars_next   = '0;
                out_bytes_next   = '0;
                out_reason_next  = u8d_pkg::REASON_END;
                out_last_next    = 1'b0;
                pend_valid_next  = head.eos;
                pend_chars_next  = sum_chars;
                pend_bytes_next  = sum_bytes;
                pend_reason_next = sum_reason;
            end
            else if (head.eos)
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = u8d_pkg::KIND_SUMMARY;
                out_cp_next     = '0;
                out_chars_next  = sum_chars;
                out_bytes_next  = sum_bytes;
                out_reason_next = sum_reason;
                out_last_next   = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            seq_length_reg <= '0;
            acc_reg        <= '0;
            bytes_done_reg <= '0;
            chars_done_reg <= '0;
            halted_reg     <= 1'b0;
            halt_cause_reg <= u8d_pkg::REASON_END;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                bytes_left_reg <= bytes_left_next;
                seq_length_reg <= seq_length_next;
                acc_reg        <= acc_next;
                bytes_done_reg <= bytes_done_next;
                chars_done_reg <= chars_done_next;
                halted_reg     <= halted_next;
                halt_cause_reg <= halt_cause_next;
            end
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_kind_reg    <= out_kind_next;
        out_cp_reg      <= out_cp_next;
        out_chars_reg   <= out_chars_next;
        out_bytes_reg   <= out_bytes_next;
        out_reason_reg  <= out_reason_next;
        out_last_reg    <= out_last_next;
        pend_chars_reg  <= pend_chars_next;
        pend_bytes_reg  <= pend_bytes_next;
        pend_reason_reg <= pend_reason_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_kind_reg;
    assign code_point     = out_cp_reg;
    assign chars_decoded  = out_chars_reg;
    assign bytes_consumed = out_bytes_reg;
    assign stop_reason    = out_reason_reg;
    assign last           = out_last_reg;

    // A pending summary always sits behind a character in the result register
    a_pend_behind_char: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (out_valid_reg && out_kind_reg == u8d_pkg::KIND_CHAR))
        else $error("pending summary without a character ahead of it");

    // Only summaries close a string
    a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == out_kind_reg))
        else $error("last flag does not match result kind");

    // Sequence length and remaining count are cleared together
    a_seq_tracks_left: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg == '0) == (seq_length_reg == '0))
        else $error("sequence length out of step with bytes left");

    // A stopped decoder holds no partial sequence and has a real cause
    a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (bytes_left_reg == '0 && halt_cause_reg != u8d_pkg::REASON_END))
        else $error("halted with partial sequence or no cause");

    // No new item is taken while a summary waits
    a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !pop)
        else $error("item popped while summary pending");

endmodule : u8d_back

`default_nettype wire

@@ rtl/utf8_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Streaming legacy UTF-8 decoder (1 to 6 byte sequences, 31-bit code
// points). Emits one request per decoded character while buffer_chars is
// nonzero, and one summary per string with counts and the stop reason.
//
//   Channel   Direction  Handshake          Payload
//   in        sink       in_valid/in_ready  data_byte, byte_present, end_of_string
//   out       source     out_valid/out_ready kind, code_point, chars_decoded,
//                                           bytes_consumed, stop_reason, last
//   cfg       sink       cfg_we             cfg_index, cfg_wdata
//
// One byte request is taken per cycle while the queue has room (in_ready high);
// results pass through a 2-entry queue and then the registered decode stage.
// A request that yields a character and a summary uses the result register
// twice, character first; that single result register sets the peak rate.
// Reset clears all control state at once; there is no clearing pass.
// When out_ready is low the result register and pending summary fill, then
// the queue, then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_core #(
    parameter int COUNT_WIDTH = u8d_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // byte input
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              byte_present,
    input  wire logic                              end_of_string,
    // results
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   kind,
    output logic [u8d_pkg::CP_W-1:0]               code_point,
    output logic [u8d_pkg::OUT_CNT_W-1:0]          chars_decoded,
    output logic [u8d_pkg::OUT_CNT_W-1:0]          bytes_consumed,
    output logic [1:0]                             stop_reason,
    output logic                                   last,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [u8d_pkg::BUF_W-1:0]         cfg_wdata
);

    logic [u8d_pkg::BUF_W-1:0] buffer_chars_reg;
    logic                      wide_16bit_reg;

    u8d_pkg::item_t            push_item;
    u8d_pkg::item_t            head;
    logic                      push;
    logic                      pop;
    logic                      head_valid;
    logic                      q_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_chars_reg <= '0;
            wide_16bit_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                u8d_pkg::CFG_BUFFER_CHARS: buffer_chars_reg <= cfg_wdata;
                u8d_pkg::CFG_WIDE_16BIT:   wide_16bit_reg   <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    u8d_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .byte_present  (byte_present),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .q_push        (push),
        .q_item        (push_item)
    );

    u8d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    u8d_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop),
        .buffer_chars   (buffer_chars_reg),
        .wide_16bit     (wide_16bit_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .code_point     (code_point),
        .chars_decoded  (chars_decoded),
        .bytes_consumed (bytes_consumed),
        .stop_reason    (stop_reason),
        .last           (last)
    );

endmodule : utf8_stream_decoder_core

`default_nettype wire
